// ===== sv/shs_pkg.sv =====
package shs_pkg;

	// Sequencer phases, shared by the top level and the compression core
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	localparam logic [5:0] FILL_LAST  = 6'd63;  // last byte slot of a block
	localparam logic [5:0] PAD_LIMIT  = 6'd56;  // first byte of the length field
	localparam logic [3:0] WORD_LAST  = 4'd15;  // last 32-bit word of a block
	localparam logic [3:0] LEN_HI_IDX = 4'd14;  // word with bit count [63:32]
	localparam logic [5:0] LOAD_LAST  = 6'd8;   // hash read sweep: 8 reads through a registered port
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [1:0] PART_LAST  = 2'd3;
	localparam logic [7:0] PAD_MARK   = 8'h80;

	// Control from the sequencer to the block buffer
	typedef struct packed {
		logic       take_byte;
		logic       pad_wr;
		logic [3:0] pad_idx;
		logic       pad_second;
		logic       pad_final;
		logic       clear;
	} buf_ctl_t;

	// Control from the sequencer to the compression core
	typedef struct packed {
		state_t     phase;
		logic [5:0] cnt;
		logic       fresh;
		logic       emit_shift;
	} core_ctl_t;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_ROUND [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ===== sv/shs_block_buf.sv =====
module shs_block_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  shs_pkg::buf_ctl_t   ctl,
	input  logic [7:0]          data_byte,
	input  logic [3:0]          raddr,
	output logic [31:0]         rdata,
	output logic [5:0]          fill,
	output logic                too_long
);

	logic [31:0] mem [16];
	logic [31:0] rdata_q;
	logic [31:0] word_q;
	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic        ovf_q;
	logic [31:0] word_next;
	logic [31:0] partial;
	logic [31:0] pad_word;
	logic        pad_first;

	assign word_next = {word_q[23:0], data_byte};

	// First padding word: bytes held so far, the 0x80 mark, then zeros
	always_comb begin
		unique case (fill_q[1:0])
			2'd0: partial = {shs_pkg::PAD_MARK, 24'h0};
			2'd1: partial = {word_q[7:0], shs_pkg::PAD_MARK, 16'h0};
			2'd2: partial = {word_q[15:0], shs_pkg::PAD_MARK, 8'h0};
			default: partial = {word_q[23:0], shs_pkg::PAD_MARK};
		endcase
	end

	assign pad_first = !ctl.pad_second && (ctl.pad_idx == fill_q[5:2]);

	// Padding word selection; bit count = byte count * 8
	always_comb begin
		priority if (pad_first) begin
			pad_word = partial;
		end else if (ctl.pad_final && ctl.pad_idx == shs_pkg::LEN_HI_IDX) begin
			pad_word = len_q[60:29];
		end else if (ctl.pad_final && ctl.pad_idx == shs_pkg::WORD_LAST) begin
			pad_word = {len_q[28:0], 3'b000};
		end else begin
			pad_word = 32'h0;
		end
	end

	// Block memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.take_byte && fill_q[1:0] == 2'd3) begin
			mem[fill_q[5:2]] <= word_next;
		end else if (ctl.pad_wr) begin
			mem[ctl.pad_idx] <= pad_word;
		end
		rdata_q <= mem[raddr];
	end

	// Byte assembly into big-endian words
	always_ff @(posedge clk) begin
		if (ctl.take_byte) begin
			word_q <= word_next;
		end
	end

	// Fill count, message length with saturation, overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (ctl.clear) begin
			fill_q <= '0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (ctl.take_byte) begin
			fill_q <= fill_q + 6'd1;
			if (&len_q) begin
				ovf_q <= 1'b1;
			end else begin
				len_q <= len_q + 61'd1;
			end
		end
	end

	assign rdata    = rdata_q;
	assign fill     = fill_q;
	assign too_long = ovf_q;

endmodule

// ===== sv/shs_compress.sv =====
module shs_compress (
	input  logic                clk,
	input  shs_pkg::core_ctl_t  ctl,
	input  logic [31:0]         blk_rdata,
	output logic [3:0]          blk_raddr,
	output logic [63:0]         digest
);

	logic [31:0] hmem [8];
	logic [31:0] hrd_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [31:0] w_q [16];
	logic [2:0]  hidx;
	logic [31:0] hval;
	logic [31:0] hsum;
	logic [31:0] sched;
	logic [31:0] wt;
	logic [31:0] t1;
	logic [31:0] t2;
	logic        in_load;
	logic        in_update;
	logic        in_round;
	logic        h_valid;

	function automatic logic [31:0] ror(input logic [31:0] x, input logic [4:0] n);
		return (x >> n) | (x << (6'd32 - {1'b0, n}));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return ror(x, 5'd2) ^ ror(x, 5'd13) ^ ror(x, 5'd22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return ror(x, 5'd6) ^ ror(x, 5'd11) ^ ror(x, 5'd25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return ror(x, 5'd7) ^ ror(x, 5'd18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return ror(x, 5'd17) ^ ror(x, 5'd19) ^ (x >> 10);
	endfunction

	assign in_load   = (ctl.phase == shs_pkg::ST_LOAD);
	assign in_update = (ctl.phase == shs_pkg::ST_UPDATE);
	assign in_round  = (ctl.phase == shs_pkg::ST_ROUND);
	assign h_valid   = (ctl.cnt != 6'd0);

	// Hash word returned this cycle; a fresh message reads the initial values
	assign hidx = ctl.cnt[2:0] - 3'd1;
	assign hval = ctl.fresh ? shs_pkg::H_INIT[hidx] : hrd_q;
	assign hsum = hval + a_q;

	// Block read runs one word ahead of the rounds
	assign blk_raddr = in_round ? (ctl.cnt[3:0] + 4'd1) : 4'd0;

	// Message schedule from the 16-word window
	assign sched = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
	assign wt    = (ctl.cnt < 6'd16) ? blk_rdata : sched;

	// One compression round
	assign t1 = h_q + bsig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q))
		+ shs_pkg::K_ROUND[ctl.cnt] + wt;
	assign t2 = bsig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	// Hash memory: read at cnt, write back at cnt-1 during the update sweep
	always_ff @(posedge clk) begin
		if (in_update && h_valid) begin
			hmem[hidx] <= hsum;
		end
		hrd_q <= hmem[ctl.cnt[2:0]];
	end

	// Working variables: load sweep, rounds, update sweep, digest shift-out
	always_ff @(posedge clk) begin
		if ((in_load || in_update) && h_valid) begin
			a_q <= b_q;
			b_q <= c_q;
			c_q <= d_q;
			d_q <= e_q;
			e_q <= f_q;
			f_q <= g_q;
			g_q <= h_q;
			h_q <= in_load ? hval : hsum;
		end else if (in_round) begin
			h_q <= g_q;
			g_q <= f_q;
			f_q <= e_q;
			e_q <= d_q + t1;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= a_q;
			a_q <= t1 + t2;
		end else if (ctl.emit_shift) begin
			a_q <= c_q;
			b_q <= d_q;
			c_q <= e_q;
			d_q <= f_q;
			e_q <= g_q;
			f_q <= h_q;
		end
	end

	// Schedule window shifts once per round
	always_ff @(posedge clk) begin
		if (in_round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wt;
		end
	end

	assign digest = {a_q, b_q};

endmodule

// ===== sv/sha256_stream_hasher_top.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------------
// input    | in_valid/in_stall  | data_byte, has_byte, end_of_message
// output   | out_valid/out_stall| digest_part, part_index, last_part, too_long
//
// One byte per cycle while a block fills. The 64th byte of a block starts a
// compression (a hash-memory read sweep, 64 rounds, a write-back sweep)
// during which input is stalled. An end mark adds 1-16 padding-word writes
// and one compression, or two of each when 56 or more bytes are held, then
// four digest items. No clearing pass after reset: a fresh flag stands in for
// the initial hash values until the hash memory is first written back.
// Output stalls hold the digest item; input stays stalled until all four go.
module sha256_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_part,
	output logic [1:0]  part_index,
	output logic        last_part,
	output logic        too_long
);

	shs_pkg::state_t    state_q, state_d;
	logic [5:0]         cnt_q, cnt_d;
	logic [3:0]         pad_idx_q, pad_idx_d;
	logic               second_q, second_d;
	logic               pad_mode_q, pad_mode_d;
	logic               eom_pend_q, eom_pend_d;
	logic               fresh_q, fresh_d;
	logic [1:0]         part_q, part_d;

	shs_pkg::buf_ctl_t  buf_ctl;
	shs_pkg::core_ctl_t core_ctl;
	logic [5:0]         fill;
	logic [5:0]         fill_after;
	logic               pad_final;
	logic               in_acc;
	logic               out_acc;
	logic               blk_full;
	logic [31:0]        blk_rdata;
	logic [3:0]         blk_raddr;

	assign in_acc     = in_valid && (state_q == shs_pkg::ST_IDLE);
	assign out_acc    = out_valid && !out_stall;
	assign fill_after = fill + {5'b0, has_byte};
	assign blk_full   = has_byte && (fill == shs_pkg::FILL_LAST);
	assign pad_final  = second_q || (fill < shs_pkg::PAD_LIMIT);

	// Next-state logic
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		pad_idx_d  = pad_idx_q;
		second_d   = second_q;
		pad_mode_d = pad_mode_q;
		eom_pend_d = eom_pend_q;
		fresh_d    = fresh_q;
		part_d     = part_q;
		unique case (state_q)
			shs_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (blk_full) begin
						state_d    = shs_pkg::ST_LOAD;
						cnt_d      = '0;
						pad_mode_d = 1'b0;
						eom_pend_d = end_of_message;
					end else if (end_of_message) begin
						state_d   = shs_pkg::ST_PAD;
						pad_idx_d = fill_after[5:2];
						second_d  = 1'b0;
					end
				end
			end
			shs_pkg::ST_PAD: begin
				if (pad_idx_q == shs_pkg::WORD_LAST) begin
					state_d    = shs_pkg::ST_LOAD;
					cnt_d      = '0;
					pad_mode_d = 1'b1;
				end else begin
					pad_idx_d = pad_idx_q + 4'd1;
				end
			end
			shs_pkg::ST_LOAD: begin
				if (cnt_q == shs_pkg::LOAD_LAST) begin
					state_d = shs_pkg::ST_ROUND;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			shs_pkg::ST_ROUND: begin
				if (cnt_q == shs_pkg::ROUND_LAST) begin
					state_d = shs_pkg::ST_UPDATE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			shs_pkg::ST_UPDATE: begin
				if (cnt_q == shs_pkg::LOAD_LAST) begin
					fresh_d = 1'b0;
					if (pad_mode_q && pad_final) begin
						state_d = shs_pkg::ST_EMIT;
						part_d  = '0;
					end else if (pad_mode_q) begin
						state_d   = shs_pkg::ST_PAD;
						pad_idx_d = '0;
						second_d  = 1'b1;
					end else if (eom_pend_q) begin
						state_d    = shs_pkg::ST_PAD;
						pad_idx_d  = '0;
						second_d   = 1'b0;
						eom_pend_d = 1'b0;
					end else begin
						state_d = shs_pkg::ST_IDLE;
					end
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			shs_pkg::ST_EMIT: begin
				if (out_acc) begin
					part_d = part_q + 2'd1;
					if (part_q == shs_pkg::PART_LAST) begin
						state_d    = shs_pkg::ST_IDLE;
						fresh_d    = 1'b1;
						eom_pend_d = 1'b0;
					end
				end
			end
			default: state_d = shs_pkg::ST_IDLE;
		endcase
	end

	// Output and control decode
	always_comb begin
		in_stall            = (state_q != shs_pkg::ST_IDLE);
		out_valid           = (state_q == shs_pkg::ST_EMIT);
		buf_ctl.take_byte   = in_acc && has_byte;
		buf_ctl.pad_wr      = (state_q == shs_pkg::ST_PAD);
		buf_ctl.pad_idx     = pad_idx_q;
		buf_ctl.pad_second  = second_q;
		buf_ctl.pad_final   = pad_final;
		buf_ctl.clear       = out_acc && (part_q == shs_pkg::PART_LAST);
		core_ctl.phase      = state_q;
		core_ctl.cnt        = cnt_q;
		core_ctl.fresh      = fresh_q;
		core_ctl.emit_shift = out_acc;
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= shs_pkg::ST_IDLE;
			cnt_q      <= '0;
			pad_idx_q  <= '0;
			second_q   <= 1'b0;
			pad_mode_q <= 1'b0;
			eom_pend_q <= 1'b0;
			fresh_q    <= 1'b1;
			part_q     <= '0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			pad_idx_q  <= pad_idx_d;
			second_q   <= second_d;
			pad_mode_q <= pad_mode_d;
			eom_pend_q <= eom_pend_d;
			fresh_q    <= fresh_d;
			part_q     <= part_d;
		end
	end

	shs_block_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (buf_ctl),
		.data_byte (data_byte),
		.raddr     (blk_raddr),
		.rdata     (blk_rdata),
		.fill      (fill),
		.too_long  (too_long)
	);

	shs_compress u_core (
		.clk       (clk),
		.ctl       (core_ctl),
		.blk_rdata (blk_rdata),
		.blk_raddr (blk_raddr),
		.digest    (digest_part)
	);

	assign part_index = part_q;
	assign last_part  = (part_q == shs_pkg::PART_LAST);

`ifndef ASSERT_OFF
	// No new item is taken while a digest is still being delivered
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while digest pending");

	// An end mark always makes the block busy on the next cycle
	a_eom_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && end_of_message) |=> in_stall)
		else $error("end of message did not start padding");

	// Digest items follow in order without a gap in valid
	a_part_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_part) |=>
		(out_valid && part_index == 2'($past(part_index) + 2'd1)))
		else $error("digest item order broken");

	// The last digest item ends the message
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_part) |=> (!out_valid && !in_stall))
		else $error("block not idle after last digest item");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_LIMIT   = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_STEP   = 150;
	localparam int ITEM_TARGET = 170;
	localparam logic [60:0] LEN_MAX = '1;

	// SHA-256 round constants and initial hash values (own copy)
	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] SHA_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct {
		logic [7:0] data;
		logic       has_byte;
		logic       eom;
		bit         drain_first;  // wait for all digests before offering
	} feed_t;

	typedef struct {
		logic [63:0] part;
		logic [1:0]  idx;
		logic        last;
		logic        too_long;
	} digest_item_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic [7:0]  data_byte      = 8'h00;
	logic        has_byte       = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_stall      = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [63:0] digest_part;
	logic [1:0]  part_index;
	logic        last_part;
	logic        too_long;

	// Hash state mirror
	logic [31:0] hv [8];
	logic [7:0]  blk [64];
	int unsigned fill;
	logic [60:0] msg_len;
	logic        len_ovf;

	digest_item_t digest_q [$];
	feed_t        pending [$];
	feed_t        cur_feed;

	int errors       = 0;
	int cycles       = 0;
	int taken_cnt    = 0;
	int owed_total   = 0;
	int seen_total   = 0;
	int gap_left     = 0;
	int wait_left    = 0;
	int hold_left    = 0;
	int next_hold_at = 40;
	int stim_items   = 0;
	int msgs         = 0;
	bit tx_burst     = 1'b0;
	bit rx_burst     = 1'b0;

	sha256_stream_hasher_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digest_part    (digest_part),
		.part_index     (part_index),
		.last_part      (last_part),
		.too_long       (too_long)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One 64-round compression of blk into hv
	function automatic void sha_compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
		e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
		for (i = 0; i < 64; i++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ SHA_K[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hv[0] = hv[0] + a; hv[1] = hv[1] + b; hv[2] = hv[2] + c; hv[3] = hv[3] + d;
		hv[4] = hv[4] + e; hv[5] = hv[5] + f; hv[6] = hv[6] + g; hv[7] = hv[7] + h;
	endfunction

	function automatic void hash_restart();
		hv = SHA_H;
		fill = 0;
		msg_len = '0;
		len_ovf = 1'b0;
	endfunction

	// Apply one accepted item; on an end mark pad, finish and queue four digest parts
	function automatic void absorb_item(input feed_t it);
		logic [63:0] bits;
		digest_item_t di;
		int f;
		int i;
		if (it.has_byte) begin
			if (msg_len == LEN_MAX)
				len_ovf = 1'b1;
			else
				msg_len = msg_len + 1'b1;
			blk[fill] = it.data;
			fill++;
			if (fill == 64) begin
				sha_compress();
				fill = 0;
			end
		end
		if (!it.eom)
			return;
		bits = {msg_len, 3'b000};
		f = fill;
		blk[f] = 8'h80;
		f++;
		// no room for the length: spill into a second block
		if (f > 56) begin
			while (f < 64) begin
				blk[f] = 8'h00;
				f++;
			end
			sha_compress();
			f = 0;
		end
		while (f < 56) begin
			blk[f] = 8'h00;
			f++;
		end
		for (i = 0; i < 8; i++)
			blk[56+i] = bits[8*(7-i) +: 8];
		sha_compress();
		for (i = 0; i < 4; i++) begin
			di.part = {hv[2*i], hv[2*i+1]};
			di.idx = i[1:0];
			di.last = (i == 3);
			di.too_long = len_ovf;
			digest_q.insert(digest_q.size(), di);
		end
		owed_total += 4;
		hash_restart();
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
		errors++;
	endtask

	task automatic push_feed(input logic [7:0] d, input logic hb, input logic em,
		input bit drain);
		feed_t it;
		it.data = d;
		it.has_byte = hb;
		it.eom = em;
		it.drain_first = drain;
		pending.insert(pending.size(), it);
		if (hb || em)
			stim_items++;
	endtask

	// Random message; the end mark rides on the last byte or comes alone
	task automatic add_message(input int len, input bit drain);
		bit joined;
		int i;
		joined = (len > 0) && ($urandom_range(0, 1) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				push_feed(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
			push_feed(8'($urandom_range(0, 255)), 1'b1, joined && (i == len - 1),
				drain && (i == 0));
		end
		if (!joined)
			push_feed(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && (len == 0));
		msgs++;
	endtask

	// Sender: one item in flight, random gap after each outside bursts
	always @(posedge clk or negedge arst_n) begin : feed_drv
		bit busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				absorb_item(cur_feed);
				taken_cnt <= taken_cnt + 1;
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending.size() == 0 ||
					(pending[0].drain_first && owed_total != seen_total)) begin
					in_valid <= 1'b0;
				end else begin
					cur_feed = pending.pop_front();
					data_byte <= cur_feed.data;
					has_byte <= cur_feed.has_byte;
					end_of_message <= cur_feed.eom;
					in_valid <= 1'b1;
					if ($urandom_range(0, 31) == 0)
						tx_burst = !tx_burst;
					gap_left = tx_burst ? 0 : $urandom_range(0, 10);
				end
			end
		end
	end

	// Long receiver hold-off, started while a digest waits, retriggered as the item count grows
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (taken_cnt >= next_hold_at && out_valid) begin
			hold_left <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + HOLD_STEP;
		end
	end

	// Receiver: check each digest part against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : digest_mon
		digest_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_total <= seen_total + 1;
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected digest_part", digest_part, '0);
				end else begin
					want = digest_q.pop_front();
					if (digest_part !== want.part)
						report_mismatch("digest_part", digest_part, want.part);
					if (part_index !== want.idx)
						report_mismatch("part_index", part_index, want.idx);
					if (last_part !== want.last)
						report_mismatch("last_part", last_part, want.last);
					if (too_long !== want.too_long)
						report_mismatch("too_long", too_long, want.too_long);
				end
				if ($urandom_range(0, 15) == 0)
					rx_burst = !rx_burst;
				wait_left = rx_burst ? 0 : $urandom_range(0, 10);
			end else if (wait_left > 0) begin
				wait_left--;
			end
			out_stall <= (wait_left != 0) || (hold_left != 0);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("FAIL sha256_stream_hasher_top");
			$finish;
		end
	end

	initial begin
		int len;
		hash_restart();
		foreach (blk[i])
			blk[i] = 8'h00;

		// Directed: empty message, lone zero byte with end mark
		push_feed(8'h00, 1'b0, 1'b1, 1'b0);
		push_feed(8'h00, 1'b1, 1'b1, 1'b0);
		// 0xff, an ignored item, then a bare end mark
		push_feed(8'hff, 1'b1, 1'b0, 1'b0);
		push_feed(8'ha5, 1'b0, 1'b0, 1'b0);
		push_feed(8'h5a, 1'b0, 1'b1, 1'b0);
		// "abc"
		push_feed(8'h61, 1'b1, 1'b0, 1'b0);
		push_feed(8'h62, 1'b1, 1'b0, 1'b0);
		push_feed(8'h63, 1'b1, 1'b1, 1'b0);
		// pause until drained, then another empty message
		push_feed(8'h3c, 1'b0, 1'b1, 1'b1);
		push_feed(8'h80, 1'b1, 1'b0, 1'b0);
		push_feed(8'h7f, 1'b1, 1'b1, 1'b0);

		// Random messages, weighted toward the padding boundaries
		while (stim_items < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: len = $urandom_range(0, 12);
				4, 5:       len = $urandom_range(54, 57);
				6, 7:       len = $urandom_range(62, 66);
				8:          len = $urandom_range(118, 121);
				default:    len = $urandom_range(13, 140);
			endcase
			if (len > ITEM_TARGET - stim_items)
				len = ITEM_TARGET - stim_items;
			add_message(len, (msgs % 5) == 4);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid || digest_q.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("PASS sha256_stream_hasher_top");
		else
			$display("FAIL sha256_stream_hasher_top");
		$finish;
	end

endmodule

// ===== files.f =====
sv/shs_pkg.sv
sv/shs_block_buf.sv
sv/shs_compress.sv
sv/sha256_stream_hasher_top.sv
dv/testbench.sv
